### hw/rtl/coordinate_pair_sorter_top_assert.svh
// Assertion macros shared by the checkers of the coordinate pair sorter.
`ifndef COORDINATE_PAIR_SORTER_TOP_ASSERT_SVH
`define COORDINATE_PAIR_SORTER_TOP_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define CPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold at every rising clock edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cps_pkg.sv
// Package with the shared types and constants of the coordinate pair sorter.
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);
  localparam int unsigned CoordW    = 32;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } cps_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;  // take the input point into the cell chain
    logic shift;   // the head point was taken, move the chain forward
  } cps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;    // exactly one point remains stored
  } cps_status_t;

  // True when point a orders strictly after point b (x first, then y).
  function automatic logic point_after(input logic signed [CoordW-1:0] ax,
                                       input logic signed [CoordW-1:0] ay,
                                       input logic signed [CoordW-1:0] bx,
                                       input logic signed [CoordW-1:0] by);
    logic res;
    if (ax != bx) begin
      res = (ax > bx);
    end else begin
      res = (ay > by);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/cps_ctrl.sv
// Controller state machine of the coordinate pair sorter: load phase and drain phase.
`timescale 1ns / 1ps
`default_nettype none
module cps_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                final_point_i,
  input  wire logic                out_ready_i,
  input  wire cps_pkg::cps_status_t status_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output cps_pkg::cps_cmd_t        cmd_o
);

  cps_pkg::cps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cps_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      cps_pkg::ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_valid_i;
        if (in_valid_i && final_point_i) begin
          state_d = cps_pkg::ST_DRAIN;
        end
      end
      cps_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
        if (out_ready_i && status_i.last) begin
          state_d = cps_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = cps_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/cps_datapath.sv
// Datapath of the coordinate pair sorter: sorted insertion cell chain, count and drop flag.
`timescale 1ns / 1ps
`default_nettype none
module cps_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cps_pkg::cps_cmd_t               cmd_i,
  input  wire logic signed [cps_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [cps_pkg::CoordW-1:0] point_y_i,
  output cps_pkg::cps_status_t                 status_o,
  output logic signed [cps_pkg::CoordW-1:0]    head_x_o,
  output logic signed [cps_pkg::CoordW-1:0]    head_y_o,
  output logic                                 dropped_o
);

  localparam int unsigned N = cps_pkg::MaxPoints;

  logic signed [cps_pkg::CoordW-1:0] x_q [N];
  logic signed [cps_pkg::CoordW-1:0] y_q [N];
  logic signed [cps_pkg::CoordW-1:0] x_d [N];
  logic signed [cps_pkg::CoordW-1:0] y_d [N];
  cps_pkg::count_t count_q, count_d;
  logic dropped_q, dropped_d;
  logic full;
  logic [N-1:0] gt;

  assign full = (count_q == cps_pkg::count_t'(N));

  // A cell orders after the new point when it is empty or holds a larger point.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (count_q <= cps_pkg::count_t'(i)) ||
              cps_pkg::point_after(x_q[i], y_q[i], point_x_i, point_y_i);
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    for (int i = 0; i < N; i++) begin
      x_d[i] = x_q[i];
      y_d[i] = y_q[i];
    end
    if (cmd_i.insert) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + cps_pkg::count_t'(1);
        for (int i = 0; i < N; i++) begin
          if (gt[i]) begin
            if (i == 0) begin
              x_d[i] = point_x_i;
              y_d[i] = point_y_i;
            end else if (!gt[i-1]) begin
              x_d[i] = point_x_i;
              y_d[i] = point_y_i;
            end else begin
              x_d[i] = x_q[i-1];
              y_d[i] = y_q[i-1];
            end
          end
        end
      end
    end else if (cmd_i.shift) begin
      count_d = count_q - cps_pkg::count_t'(1);
      for (int i = 0; i < N - 1; i++) begin
        x_d[i] = x_q[i+1];
        y_d[i] = y_q[i+1];
      end
      if (count_q == cps_pkg::count_t'(1)) begin
        dropped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      x_q[i] <= x_d[i];
      y_q[i] <= y_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign status_o.last = (count_q == cps_pkg::count_t'(1));
  assign head_x_o      = x_q[0];
  assign head_y_o      = y_q[0];
  assign dropped_o     = dropped_q;

endmodule
`default_nettype wire

### hw/rtl/coordinate_pair_sorter_top.sv
// A set's first sorted point is offered in the cycle after its final request is taken.
// Throughput: one point request per cycle while loading, one result per cycle while draining and out_ready_i is high.
// A set is loaded in full and then drained in full before the next set's first request is
// taken; the parallel compare over the insertion cell chain sets the load rate.
// Reset (rst_ni low, asynchronous) empties the store and clears the drop flag; the
// block then waits in the load phase.
`timescale 1ns / 1ps
`default_nettype none
module coordinate_pair_sorter_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Point requests.
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [cps_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [cps_pkg::CoordW-1:0] point_y_i,
  input  wire logic                              final_point_i,
  // Sorted results.
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [cps_pkg::CoordW-1:0]      sorted_x_o,
  output logic signed [cps_pkg::CoordW-1:0]      sorted_y_o,
  output logic                                   end_of_run_o,
  output logic                                   overflow_o
);

  // The controller alternates between a load phase, in which each request is
  // inserted into its sorted place in the cell chain, and a drain phase, in
  // which the head of the chain is presented and the chain moves forward each
  // time a result is taken.
  cps_pkg::cps_cmd_t    cmd;
  cps_pkg::cps_status_t status;
  logic                 dropped;

  cps_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .final_point_i (final_point_i),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  // The cell chain always holds the stored points in ascending order, so the
  // head cell is the next result. Points that arrive while the chain is full
  // are dropped and remembered for the last result of the set.
  cps_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .status_o  (status),
    .head_x_o  (sorted_x_o),
    .head_y_o  (sorted_y_o),
    .dropped_o (dropped)
  );

  // The last result of a set is the one presented while a single point remains.
  assign end_of_run_o = status.last;
  assign overflow_o   = status.last && dropped;

endmodule
`default_nettype wire

### hw/rtl/cps_checker.sv
// Port-level checker of the coordinate pair sorter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "coordinate_pair_sorter_top_assert.svh"
module cps_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         final_point_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [cps_pkg::CoordW-1:0]   sorted_x_o,
  input wire logic [cps_pkg::CoordW-1:0]   sorted_y_o,
  input wire logic                         end_of_run_o,
  input wire logic                         overflow_o
);

  // The block either takes points or offers results, never both at once.
  `CPS_ASSERT_ALWAYS(a_phase_excl, clk_i, !(in_ready_o && out_valid_o), "load and drain overlap")

  // Overflow is reported only on the last result of a set.
  `CPS_ASSERT(a_ovf_last, clk_i, rst_ni, out_valid_o && overflow_o |-> end_of_run_o,
              "overflow outside last result")

  // A final point request starts the drain in the next cycle.
  `CPS_ASSERT(a_final_drain, clk_i, rst_ni,
              in_valid_i && in_ready_o && final_point_i |=> out_valid_o,
              "no result after final point")

  // Taking the last result returns the block to loading.
  `CPS_ASSERT(a_end_load, clk_i, rst_ni,
              out_valid_o && out_ready_i && end_of_run_o |=> in_ready_o && !out_valid_o,
              "no return to loading after last result")

  // A stalled result holds its payload.
  `CPS_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=> out_valid_o && $stable(sorted_x_o) &&
              $stable(sorted_y_o) && $stable(end_of_run_o),
              "stalled result changed")

endmodule

bind coordinate_pair_sorter_top cps_checker u_cps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .final_point_i (final_point_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .sorted_x_o    (sorted_x_o),
  .sorted_y_o    (sorted_y_o),
  .end_of_run_o  (end_of_run_o),
  .overflow_o    (overflow_o)
);
`default_nettype wire

### sim/tb_coordinate_pair_sorter_top.sv
// Self-checking testbench for the coordinate pair sorter: random point sets against a sorting scoreboard.
`timescale 1ns / 1ps

typedef struct {
  logic signed [cps_pkg::CoordW-1:0] x;
  logic signed [cps_pkg::CoordW-1:0] y;
} coord_pair_t;

typedef struct {
  coord_pair_t pt;
  logic        eor;
  logic        ovf;
} sorted_point_t;

// Keeps its own copy of the loaded set, sorts it when the final request
// arrives, and queues the sorted points that the block must emit.
class sorted_point_board;
  coord_pair_t   held[$];
  bit            dropped;
  sorted_point_t sorted_due[$];
  int            errors;

  function new();
    dropped = 1'b0;
    errors  = 0;
  endfunction

  // Lexicographic order: x decides, y breaks ties.
  function bit orders_after(coord_pair_t a, coord_pair_t b);
    if (a.x != b.x) begin
      return a.x > b.x;
    end
    return a.y > b.y;
  endfunction

  function void note_point(logic signed [cps_pkg::CoordW-1:0] x,
                           logic signed [cps_pkg::CoordW-1:0] y, logic fin);
    coord_pair_t   p;
    coord_pair_t   key;
    sorted_point_t r;
    int            i;
    int            j;
    p.x = x;
    p.y = y;
    if (held.size() < cps_pkg::MaxPoints) begin
      held.push_back(p);
    end else begin
      dropped = 1'b1;
    end
    if (fin) begin
      for (i = 1; i < held.size(); i++) begin
        key = held[i];
        j   = i;
        while (j > 0 && orders_after(held[j-1], key)) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = key;
      end
      for (i = 0; i < held.size(); i++) begin
        r.pt  = held[i];
        r.eor = (i == held.size() - 1);
        r.ovf = r.eor && dropped;
        sorted_due.push_back(r);
      end
      held.delete();
      dropped = 1'b0;
    end
  endfunction

  function void check_field(string name, logic signed [cps_pkg::CoordW-1:0] want,
                            logic signed [cps_pkg::CoordW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic signed [cps_pkg::CoordW-1:0] x,
                             logic signed [cps_pkg::CoordW-1:0] y, logic eor, logic ovf);
    sorted_point_t w;
    if (sorted_due.size() == 0) begin
      $display("%0t: unexpected sorted point x=%0d y=%0d end_of_run=%0b overflow=%0b",
               $time, x, y, eor, ovf);
      errors++;
      return;
    end
    w = sorted_due.pop_front();
    check_field("sorted_x", w.pt.x, x);
    check_field("sorted_y", w.pt.y, y);
    check_field("end_of_run", {31'd0, w.eor}, {31'd0, eor});
    check_field("overflow", {31'd0, w.ovf}, {31'd0, ovf});
  endfunction
endclass

module tb_coordinate_pair_sorter_top;

  localparam int CycleLimit = 200000;
  localparam int HoldOff    = 400;
  localparam int SettleCyc  = 2 * cps_pkg::MaxPoints + 20;
  localparam int RandItems  = 160;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [cps_pkg::CoordW-1:0] point_x_i;
  logic signed [cps_pkg::CoordW-1:0] point_y_i;
  logic                              final_point_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [cps_pkg::CoordW-1:0] sorted_x_o;
  logic signed [cps_pkg::CoordW-1:0] sorted_y_o;
  logic                              end_of_run_o;
  logic                              overflow_o;

  sorted_point_board board;
  int                cycle_count = 0;
  bit                tx_burst    = 1'b0;
  int                sent_count  = 0;

  coordinate_pair_sorter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .final_point_i (final_point_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_x_o    (sorted_x_o),
    .sorted_y_o    (sorted_y_o),
    .end_of_run_o  (end_of_run_o),
    .overflow_o    (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mix of extremes, a small pool that makes equal coordinates common, and full-range values.
  function automatic logic signed [cps_pkg::CoordW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Offers one point request and returns once the block has taken it. Inputs change
  // only at rising edges, so ready is sampled at the falling edge in between.
  task automatic send_point(input logic signed [cps_pkg::CoordW-1:0] x,
                            input logic signed [cps_pkg::CoordW-1:0] y, input logic fin);
    int gap;
    bit took;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_x_i     <= x;
    point_y_i     <= y;
    final_point_i <= fin;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    board.note_point(x, y, fin);
    sent_count++;
  endtask

  task automatic send_random_set(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_point(pick_coord(), pick_coord(), k == count - 1);
    end
  endtask

  // Takes sorted points with random stalls. After the third result the receiver
  // holds off for a long stretch so that the block backs up into its input.
  task automatic drain_results();
    int                                gap;
    int                                seen;
    bit                                took;
    bit                                burst;
    logic signed [cps_pkg::CoordW-1:0] rx;
    logic signed [cps_pkg::CoordW-1:0] ry;
    logic                              reor;
    logic                              rovf;
    seen  = 0;
    burst = 1'b0;
    forever begin
      if (seen == 3) begin
        out_ready_i <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        rx   = sorted_x_o;
        ry   = sorted_y_o;
        reor = end_of_run_o;
        rovf = overflow_o;
        @(posedge clk_i);
      end while (!took);
      board.check_result(rx, ry, reor, rovf);
      seen++;
    end
  endtask

  initial begin
    int set_no;
    int size;
    board         = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    point_x_i     = '0;
    point_y_i     = '0;
    final_point_i = 1'b0;
    out_ready_i   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_results();
    join_none

    // Extremes of both coordinates, ties on x, and a repeated point.
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(0, -1, 1'b0);
    send_point(0, 1, 1'b0);
    send_point(-1, 0, 1'b0);
    send_point(0, -1, 1'b1);
    // A set of a single point.
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    // Equal x with y at both extremes.
    send_point(-1, 32'sh7fff_ffff, 1'b0);
    send_point(-1, 32'sh8000_0000, 1'b0);
    send_point(1, 0, 1'b1);
    // Identical points only.
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);

    // Random sets. One fills the store exactly, and one more loses its final
    // point to a full store and must report the drop.
    set_no = 0;
    while (sent_count < RandItems) begin
      if (set_no == 2) begin
        size = cps_pkg::MaxPoints;
      end else if (set_no == 5) begin
        size = cps_pkg::MaxPoints + 1;
      end else begin
        size = $urandom_range(1, 10);
      end
      send_random_set(size);
      set_no++;
    end
    in_valid_i <= 1'b0;

    while (board.sorted_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (board.errors == 0 && board.sorted_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
